### rtl/tdpt_pkg.sv
// tdpt_pkg: shared types and constants for the trial division prime test
// no dependencies; imported by tdpt_ctrl, tdpt_dp and trial_division_prime_test

package tdpt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int S_DATA_W    = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W    = ((VALUE_WIDTH + 1 + 7) / 8) * 8;

    localparam logic [VALUE_WIDTH-1:0] DIV_FIRST = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] DIV_INC   = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] VAL_TWO   = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] VAL_FOUR  = VALUE_WIDTH'(4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIV,
        ST_TEST,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start_first;
        logic step;
        logic next_div;
        logic set_verdict;
        logic verdict;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic neg;
        logic lt2;
        logic lt4;
        logic even;
        logic div_last;
        logic quo_lt_div;
        logic rem_zero;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/tdpt_ctrl.sv
// tdpt_ctrl: sequencer for one test, drives the datapath through commands
// depends on tdpt_pkg

module tdpt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  tdpt_pkg::t_dp_status  i_status,
    output tdpt_pkg::t_dp_cmd     o_cmd
);
    import tdpt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (i_status.neg || i_status.lt2 || i_status.lt4 || i_status.even) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                if (i_status.quo_lt_div || i_status.rem_zero) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_CLASSIFY: begin
                if (i_status.neg || i_status.lt2) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                end else if (i_status.lt4) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b1;
                end else if (i_status.even) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                end else begin
                    o_cmd.start_first = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_TEST: begin
                if (i_status.quo_lt_div) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b1;
                end else if (i_status.rem_zero) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                end else begin
                    o_cmd.next_div = 1'b1;
                end
            end
            ST_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd      = '0;
                o_s_tready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_step_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (r_state == ST_DIV))
        else $error("divider stepped outside the divide state");
    a_div_then_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_last) |=> (r_state == ST_TEST))
        else $error("divide did not hand over to the test state");
    a_out_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == ST_IDLE))
        else $error("result loaded without return to idle");
`endif

endmodule

### rtl/tdpt_dp.sv
// tdpt_dp: value capture, bit-serial restoring divider, verdict and output register
// depends on tdpt_pkg

module tdpt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [tdpt_pkg::VALUE_WIDTH-1:0]    i_value,
    input  logic                                i_last,
    input  tdpt_pkg::t_dp_cmd                   i_cmd,
    output tdpt_pkg::t_dp_status                o_status,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [tdpt_pkg::VALUE_WIDTH-1:0]    o_tested_value,
    output logic                                o_is_prime,
    output logic                                o_last
);
    import tdpt_pkg::*;

    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_last;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_verdict;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_prime;
    logic                   r_out_last;

    logic [VALUE_WIDTH-1:0] n_rem_sh;
    logic                   n_ge;
    logic [VALUE_WIDTH-1:0] n_rem;

    assign n_rem_sh = {r_rem[VALUE_WIDTH-2:0], r_quo[VALUE_WIDTH-1]};
    assign n_ge     = (n_rem_sh >= r_div);
    assign n_rem    = n_ge ? (n_rem_sh - r_div) : n_rem_sh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_last  <= i_last;
        end
        if (i_cmd.start_first) begin
            r_div <= DIV_FIRST;
        end else if (i_cmd.next_div) begin
            r_div <= r_div + DIV_INC;
        end
        if (i_cmd.start_first || i_cmd.next_div) begin
            r_quo <= r_value;
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], n_ge};
            r_rem <= n_rem;
        end
        if (i_cmd.set_verdict) begin
            r_verdict <= i_cmd.verdict;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_value;
            r_out_prime <= r_verdict;
            r_out_last  <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_first || i_cmd.next_div) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.neg        = r_value[VALUE_WIDTH-1];
        o_status.lt2        = (r_value < VAL_TWO);
        o_status.lt4        = (r_value < VAL_FOUR);
        o_status.even       = !r_value[0];
        o_status.div_last   = (r_cnt == CNT_W'(VALUE_WIDTH - 1));
        o_status.quo_lt_div = (r_quo < r_div);
        o_status.rem_zero   = (r_rem == '0);
        o_status.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_tested_value = r_out_value;
    assign o_is_prime     = r_out_prime;
    assign o_last         = r_out_last;

`ifndef NO_ASSERTIONS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.step) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_div[0])
        else $error("even trial divisor");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten before taken");
`endif

endmodule

### rtl/trial_division_prime_test.sv
// trial_division_prime_test: top level, one signed value per beat, prime flag out
// flow: negatives, values below 4 and even values pass from idle through classify to the output state;
// other odd values add a divide state and a test state for each odd trial divisor 3, 5, ... up to the
// first divisor that divides the value or whose square exceeds it; the output state waits for a free result register
// one value at a time: o_s_tready is high only in idle, so the next beat waits until the result is loaded
// reset: synchronous active-low, returns the sequencer to idle and drops o_m_tvalid
// depends on tdpt_pkg, tdpt_ctrl, tdpt_dp

module trial_division_prime_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [tdpt_pkg::S_DATA_W-1:0]   i_s_tdata,   // value
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [tdpt_pkg::M_DATA_W-1:0]   o_m_tdata,   // tested_value, is_prime, zero pad
    output logic                            o_m_tlast
);
    import tdpt_pkg::*;

    t_dp_cmd                w_cmd;
    t_dp_status             w_status;
    logic [VALUE_WIDTH-1:0] w_tested_value;
    logic                   w_is_prime;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tdpt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_last         (i_s_tlast),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_tested_value (w_tested_value),
        .o_is_prime     (w_is_prime),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = M_DATA_W'({w_is_prime, w_tested_value});

`ifndef NO_ASSERTIONS
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken again before the test finished");
    a_no_negative_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[VALUE_WIDTH] && o_m_tdata[VALUE_WIDTH-1]))
        else $error("negative value flagged prime");
    a_even_prime_is_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[VALUE_WIDTH] && !o_m_tdata[0])
            |-> (o_m_tdata[VALUE_WIDTH-1:0] == VAL_TWO))
        else $error("even value other than two flagged prime");
`endif

endmodule

### bench/tdpt_prime_checker.sv
// tdpt_prime_checker: watches both stream channels of the prime test, predicts each result
// and compares it with the beat the block sends; depends on tdpt_pkg only
`timescale 1ns / 100ps

module tdpt_prime_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [tdpt_pkg::S_DATA_W-1:0]   i_s_tdata,   // value
    input  logic                            i_s_tlast,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [tdpt_pkg::M_DATA_W-1:0]   i_m_tdata,   // tested_value, is_prime, zero pad
    input  logic                            i_m_tlast,
    output int                              o_pending,
    output int                              o_mismatches
);

    localparam int VW = tdpt_pkg::VALUE_WIDTH;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          prime;
        logic          last;
    } t_prime_result;

    t_prime_result awaited_q[$];
    int            mismatch_count = 0;

    function automatic logic prime_verdict(input logic [VW-1:0] raw);
        longint unsigned v;
        longint unsigned d;
        if (raw[VW-1])
            return 1'b0;
        v = raw;
        if (v < 2)
            return 1'b0;
        if (v < 4)
            return 1'b1;
        if (v % 2 == 0)
            return 1'b0;
        for (d = 3; d <= v / d; d += 2) begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_prime_result want;
        t_prime_result got;
        if (i_rst_n) begin
            // results first, so a beat can never match an item taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata[VW-1:0];
                got.prime = i_m_tdata[VW];
                got.last  = i_m_tlast;
                if (awaited_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result beat value=%0d prime=%0b last=%0b",
                                 $realtime, $signed(got.value), got.prime, got.last);
                end else begin
                    want = awaited_q.pop_front();
                    if (got.value !== want.value || got.prime !== want.prime ||
                        got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display(
                                "%0t: mismatch exp/act value %0d/%0d prime %0b/%0b last %0b/%0b",
                                $realtime, $signed(want.value), $signed(got.value),
                                want.prime, got.prime, want.last, got.last);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want.value = i_s_tdata[VW-1:0];
                want.prime = prime_verdict(i_s_tdata[VW-1:0]);
                want.last  = i_s_tlast;
                awaited_q.push_back(want);
            end
        end
        o_pending    <= awaited_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

### bench/tb_trial_division_prime_test.sv
// tb_trial_division_prime_test: drives values into the prime test with random idling on both
// sides and gives the verdict; depends on tdpt_pkg, the block and tdpt_prime_checker
`timescale 1ns / 100ps

module tb_trial_division_prime_test;

    localparam int VW           = tdpt_pkg::VALUE_WIDTH;
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tdpt_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tdpt_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tlast;

    int pending;
    int mismatches;
    int cycle_count = 0;
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    int hold_req    = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    trial_division_prime_test DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    tdpt_prime_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [VW-1:0] pick_value();
        int unsigned r;
        int unsigned p;
        int unsigned odd_primes[14];
        odd_primes = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(0, 31);
        if (r < 50)
            return $urandom_range(0, 4095);
        if (r < 62)
            return $urandom | 32'h8000_0000;
        if (r < 72)
            return $urandom & 32'h7fff_fffe;
        if (r < 94) begin
            // large multiples of a small odd prime keep the search short
            p = odd_primes[$urandom_range(0, 13)];
            return p * $urandom_range(1, 32'h7fff_ffff / p);
        end
        if (r < 99)
            return $urandom_range(4096, 1 << 18);
        return $urandom_range(1 << 18, 1 << 22);
    endfunction

    task automatic send_beat(input logic [VW-1:0] v, input logic last);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // timeout
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : sink
        int stall;
        int hold_seen;
        hold_seen = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                stall = HOLD_CYCLES;
            end else begin
                stall = sink_steady ? 0 : pick_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial begin : stimulus
        int phase;
        int sent;
        int run_len;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, one, small primes and squares, negatives, both range ends
        send_beat(32'd0, 1'b0);
        send_beat(32'd1, 1'b0);
        send_beat(32'd2, 1'b0);
        send_beat(32'd3, 1'b1);
        send_beat(32'd4, 1'b0);
        send_beat(32'd5, 1'b0);
        send_beat(32'd9, 1'b0);
        send_beat(32'd25, 1'b0);
        send_beat(32'd49, 1'b1);
        send_beat(32'd97, 1'b0);
        send_beat(32'd65521, 1'b0);
        send_beat(32'd65535, 1'b0);
        send_beat(32'd1042441, 1'b0);
        send_beat(32'd1000003, 1'b1);
        send_beat(32'hffff_ffff, 1'b0);
        send_beat(32'hffff_fffe, 1'b0);
        send_beat(32'h8000_0000, 1'b1);
        send_beat(32'h7fff_fffe, 1'b0);
        send_beat(32'h5555_5555, 1'b0);
        send_beat(32'h7fff_ffff, 1'b1);
        settle();

        // receiver holds off while the source keeps offering
        src_steady = 1'b1;
        hold_req++;
        repeat (12)
            send_beat(32'($urandom_range(0, 2000)) & 32'hffff_fffe, 1'($urandom_range(0, 1)));
        src_steady = 1'b0;
        settle();

        for (phase = 0; phase < 6; phase++) begin
            src_steady  = (phase == 1 || phase == 3);
            sink_steady = (phase == 2 || phase == 3);
            sent = 0;
            while (sent < 100) begin
                run_len = $urandom_range(1, 12);
                for (int k = 0; k < run_len; k++)
                    send_beat(pick_value(), k == run_len - 1);
                sent += run_len;
            end
            settle();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/tdpt_pkg.sv
rtl/tdpt_ctrl.sv
rtl/tdpt_dp.sv
rtl/trial_division_prime_test.sv
bench/tdpt_prime_checker.sv
bench/tb_trial_division_prime_test.sv
